[design/det_pkg.sv]
`timescale 1ns / 1ps
package det_pkg;

    // Field and store widths
    localparam int VERT_W  = 6;
    localparam int EDGE_W  = 7;
    localparam int CNT_W   = 7;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 2;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 63;

    // Marker for a vertex with no unused edge left
    localparam logic [EDGE_W-1:0] LIST_EMPTY = 7'h7F;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTEX_COUNT = 2'd0,
        CFG_START_VERTEX = 2'd1,
        CFG_END_VERTEX   = 2'd2
    } cfg_idx_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic add_edge;
        logic bal_start;
        logic bal_read;
        logic bal_next;
        logic walk_init;
        logic top_read;
        logic retire;
        logic edge_read;
        logic pop_load;
        logic push;
        logic emit_start;
        logic emit_read;
        logic emit_load;
        logic fail_load;
        logic clear;
    } det_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_item;
        logic pre_bad;
        logic bal_ok;
        logic bal_last;
        logic top_empty;
        logic sp_one;
        logic len_ok;
        logic out_free;
        logic idx_zero;
    } det_sts_t;

endpackage

[design/det_ctrl.sv]
`timescale 1ns / 1ps
module det_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  det_pkg::det_sts_t sts,
    output det_pkg::det_cmd_t cmd
);

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_LOAD      = 15'b000000000000010,
        S_CHECK     = 15'b000000000000100,
        S_BAL_RD    = 15'b000000000001000,
        S_BAL_CMP   = 15'b000000000010000,
        S_WALK_INIT = 15'b000000000100000,
        S_TOP_RD    = 15'b000000001000000,
        S_TOP_DEC   = 15'b000000010000000,
        S_EDGE      = 15'b000000100000000,
        S_POP       = 15'b000001000000000,
        S_LEN_CHK   = 15'b000010000000000,
        S_EMIT_RD   = 15'b000100000000000,
        S_EMIT_LD   = 15'b001000000000000,
        S_FAIL      = 15'b010000000000000,
        S_CLEAR     = 15'b100000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.add_edge = 1'b1;
                state_next   = sts.last_item ? S_CHECK : S_IDLE;
            end
            S_CHECK: begin
                if (sts.pre_bad) begin
                    state_next = S_FAIL;
                end else begin
                    cmd.bal_start = 1'b1;
                    state_next    = S_BAL_RD;
                end
            end
            S_BAL_RD: begin
                cmd.bal_read = 1'b1;
                state_next   = S_BAL_CMP;
            end
            S_BAL_CMP: begin
                if (!sts.bal_ok) begin
                    state_next = S_FAIL;
                end else if (sts.bal_last) begin
                    state_next = S_WALK_INIT;
                end else begin
                    cmd.bal_next = 1'b1;
                    state_next   = S_BAL_RD;
                end
            end
            S_WALK_INIT: begin
                cmd.walk_init = 1'b1;
                state_next    = S_TOP_RD;
            end
            S_TOP_RD: begin
                cmd.top_read = 1'b1;
                state_next   = S_TOP_DEC;
            end
            S_TOP_DEC: begin
                if (sts.top_empty) begin
                    cmd.retire = 1'b1;
                    state_next = sts.sp_one ? S_LEN_CHK : S_POP;
                end else begin
                    cmd.edge_read = 1'b1;
                    state_next    = S_EDGE;
                end
            end
            S_EDGE: begin
                cmd.push   = 1'b1;
                state_next = S_TOP_RD;
            end
            S_POP: begin
                cmd.pop_load = 1'b1;
                state_next   = S_TOP_RD;
            end
            S_LEN_CHK: begin
                if (sts.len_ok) begin
                    cmd.emit_start = 1'b1;
                    state_next     = S_EMIT_RD;
                end else begin
                    state_next = S_FAIL;
                end
            end
            S_EMIT_RD: begin
                cmd.emit_read = 1'b1;
                state_next    = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (sts.out_free) begin
                    cmd.emit_load = 1'b1;
                    state_next    = sts.idx_zero ? S_CLEAR : S_EMIT_RD;
                end
            end
            S_FAIL: begin
                if (sts.out_free) begin
                    cmd.fail_load = 1'b1;
                    state_next    = S_CLEAR;
                end
            end
            S_CLEAR: begin
                cmd.clear  = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[design/det_dp.sv]
`timescale 1ns / 1ps
module det_dp #(
    parameter int MAX_VERTICES = det_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = det_pkg::DEF_MAX_EDGES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [det_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [det_pkg::CFG_W-1:0]     cfg_data,
    input  logic [15:0]                   s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast,
    input  det_pkg::det_cmd_t             cmd,
    output det_pkg::det_sts_t             sts
);

    localparam int VAW    = $clog2(MAX_VERTICES);
    localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int SDEPTH = MAX_EDGES + 1;
    localparam int SAW    = $clog2(SDEPTH);
    localparam int VW     = det_pkg::VERT_W;
    localparam int EW     = det_pkg::EDGE_W;
    localparam int CW     = det_pkg::CNT_W;
    localparam logic [CW-1:0] NV = CW'(MAX_VERTICES);
    localparam logic [CW-1:0] NE = CW'(MAX_EDGES);
    localparam logic [CW-1:0] ND = CW'(SDEPTH);

    // Configuration registers
    logic [CW-1:0] vcount_reg;
    logic [VW-1:0] start_reg;
    logic [VW-1:0] end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= CW'(1);
            start_reg  <= '0;
            end_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                det_pkg::CFG_VERTEX_COUNT: vcount_reg <= cfg_data[CW-1:0];
                det_pkg::CFG_START_VERTEX: start_reg  <= cfg_data[VW-1:0];
                det_pkg::CFG_END_VERTEX:   end_reg    <= cfg_data[VW-1:0];
                default: ;
            endcase
        end
    end

    // Active vertex count, clamped to 1..MAX_VERTICES
    logic [CW-1:0] n_act;
    assign n_act = (vcount_reg == '0) ? CW'(1) : ((vcount_reg > NV) ? NV : vcount_reg);

    // Captured input item
    logic [VW-1:0] from_reg;
    logic [VW-1:0] to_reg;
    logic          has_reg;
    logic          last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            from_reg <= s_tdata[VW-1:0];
            to_reg   <= s_tdata[2*VW-1:VW];
            has_reg  <= s_tuser;
            last_reg <= s_tlast;
        end
    end

    // Walk and emit registers
    logic [CW-1:0] edge_total_reg;
    logic          fault_reg;
    logic [CW-1:0] u_reg;
    logic [VW-1:0] top_reg;
    logic [CW-1:0] sp_reg;
    logic [CW-1:0] len_reg;
    logic [CW-1:0] idx_reg;

    // Per-vertex entry valid bits; an invalid entry reads as empty or zero
    logic [MAX_VERTICES-1:0] lt_vld_reg;
    logic [MAX_VERTICES-1:0] in_vld_reg;
    logic [MAX_VERTICES-1:0] out_vld_reg;

    // Memory read data
    logic [EW-1:0] lt_rd;
    logic [CW-1:0] in_rd;
    logic [CW-1:0] out_rd;
    logic [VW-1:0] head_rd;
    logic [EW-1:0] next_rd;
    logic [VW-1:0] stack_rd;
    logic [VW-1:0] trail_rd;

    logic [VAW-1:0] from_a;
    logic [VAW-1:0] to_a;
    logic [VAW-1:0] u_a;
    logic [VAW-1:0] top_a;
    assign from_a = from_reg[VAW-1:0];
    assign to_a   = to_reg[VAW-1:0];
    assign u_a    = u_reg[VAW-1:0];
    assign top_a  = top_reg[VAW-1:0];

    // Edge add decision
    logic          edge_bad;
    logic          edge_wr;
    logic [EW-1:0] lt_old;
    logic [CW-1:0] in_new;
    logic [CW-1:0] out_new;
    assign edge_bad = ({1'b0, from_reg} >= n_act) || ({1'b0, to_reg} >= n_act)
                      || (edge_total_reg >= NE);
    assign edge_wr  = cmd.add_edge && has_reg && !edge_bad;
    assign lt_old   = lt_vld_reg[from_a] ? lt_rd : det_pkg::LIST_EMPTY;
    assign in_new   = (in_vld_reg[to_a] ? in_rd : '0) + CW'(1);
    assign out_new  = (out_vld_reg[from_a] ? out_rd : '0) + CW'(1);

    // Current list head of the vertex on top of the stack
    logic [EW-1:0] cur_e;
    logic          top_empty;
    assign cur_e     = lt_vld_reg[top_a] ? lt_rd : det_pkg::LIST_EMPTY;
    assign top_empty = (cur_e >= NE);

    // Read address selection
    logic [VAW-1:0] lt_ra;
    logic [VAW-1:0] cnt_in_ra;
    logic [VAW-1:0] cnt_out_ra;
    logic [CW-1:0]  sp_m2;
    assign lt_ra      = cmd.capture ? s_tdata[VAW-1:0] : top_a;
    assign cnt_in_ra  = cmd.capture ? s_tdata[VW+VAW-1:VW] : u_a;
    assign cnt_out_ra = cmd.capture ? s_tdata[VAW-1:0] : u_a;
    assign sp_m2      = sp_reg - CW'(2);

    // Edge store: head vertex and next edge of the same tail
    logic [VW-1:0] edge_head_mem [0:MAX_EDGES-1];
    logic [EW-1:0] edge_next_mem [0:MAX_EDGES-1];

    always_ff @(posedge aclk) begin
        if (edge_wr) begin
            edge_head_mem[edge_total_reg[EAW-1:0]] <= to_reg;
            edge_next_mem[edge_total_reg[EAW-1:0]] <= lt_old;
        end
        if (cmd.edge_read) begin
            head_rd <= edge_head_mem[cur_e[EAW-1:0]];
            next_rd <= edge_next_mem[cur_e[EAW-1:0]];
        end
    end

    // Newest unused edge per vertex
    logic [EW-1:0] list_top_mem [0:MAX_VERTICES-1];

    always_ff @(posedge aclk) begin
        if (edge_wr) begin
            list_top_mem[from_a] <= edge_total_reg;
        end else if (cmd.push) begin
            list_top_mem[top_a] <= next_rd;
        end
        if (cmd.capture || cmd.top_read) begin
            lt_rd <= list_top_mem[lt_ra];
        end
    end

    // Degree counts
    logic [CW-1:0] in_count_mem  [0:MAX_VERTICES-1];
    logic [CW-1:0] out_count_mem [0:MAX_VERTICES-1];

    always_ff @(posedge aclk) begin
        if (edge_wr) begin
            in_count_mem[to_a]    <= in_new;
            out_count_mem[from_a] <= out_new;
        end
        if (cmd.capture || cmd.bal_read) begin
            in_rd  <= in_count_mem[cnt_in_ra];
            out_rd <= out_count_mem[cnt_out_ra];
        end
    end

    // Walk stack; top of stack is also held in top_reg
    logic [VW-1:0] walk_stack_mem [0:SDEPTH-1];

    always_ff @(posedge aclk) begin
        if (cmd.walk_init) begin
            walk_stack_mem[0] <= start_reg;
        end else if (cmd.push) begin
            walk_stack_mem[sp_reg[SAW-1:0]] <= head_rd;
        end
        if (cmd.retire) begin
            stack_rd <= walk_stack_mem[sp_m2[SAW-1:0]];
        end
    end

    // Trail in retire order (reverse of the output order)
    logic [VW-1:0] trail_mem [0:SDEPTH-1];

    always_ff @(posedge aclk) begin
        if (cmd.retire) begin
            trail_mem[len_reg[SAW-1:0]] <= top_reg;
        end
        if (cmd.emit_read) begin
            trail_rd <= trail_mem[idx_reg[SAW-1:0]];
        end
    end

    // Graph bookkeeping and valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            edge_total_reg <= '0;
            fault_reg      <= 1'b0;
            lt_vld_reg     <= '0;
            in_vld_reg     <= '0;
            out_vld_reg    <= '0;
        end else if (cmd.add_edge && has_reg) begin
            if (edge_bad) begin
                fault_reg <= 1'b1;
            end else begin
                edge_total_reg     <= edge_total_reg + CW'(1);
                lt_vld_reg[from_a] <= 1'b1;
                in_vld_reg[to_a]   <= 1'b1;
                out_vld_reg[from_a] <= 1'b1;
            end
        end
    end

    // Balance scan counter
    always_ff @(posedge aclk) begin
        if (cmd.bal_start) begin
            u_reg <= '0;
        end else if (cmd.bal_next) begin
            u_reg <= u_reg + CW'(1);
        end
    end

    // Balance compare: in + [u == start] versus out + [u == end]
    logic [CW:0] bal_lhs;
    logic [CW:0] bal_rhs;
    assign bal_lhs = {1'b0, (in_vld_reg[u_a] ? in_rd : '0)}
                     + (CW+1)'(u_reg == {1'b0, start_reg});
    assign bal_rhs = {1'b0, (out_vld_reg[u_a] ? out_rd : '0)}
                     + (CW+1)'(u_reg == {1'b0, end_reg});

    // Stack walk registers
    always_ff @(posedge aclk) begin
        if (cmd.walk_init) begin
            top_reg <= start_reg;
            sp_reg  <= CW'(1);
            len_reg <= '0;
        end else if (cmd.retire) begin
            len_reg <= len_reg + CW'(1);
            sp_reg  <= sp_reg - CW'(1);
        end else if (cmd.pop_load) begin
            top_reg <= stack_rd;
        end else if (cmd.push) begin
            top_reg <= head_rd;
            sp_reg  <= sp_reg + CW'(1);
        end
    end

    // Emit index, counts down to the first retired vertex
    always_ff @(posedge aclk) begin
        if (cmd.emit_start) begin
            idx_reg <= len_reg - CW'(1);
        end else if (cmd.emit_load) begin
            idx_reg <= idx_reg - CW'(1);
        end
    end

    // Output register
    logic          m_tvalid_reg;
    logic [VW-1:0] m_vert_reg;
    logic          m_tuser_reg;
    logic          m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit_load || cmd.fail_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            m_vert_reg  <= trail_rd;
            m_tuser_reg <= 1'b0;
            m_tlast_reg <= (idx_reg == '0);
        end else if (cmd.fail_load) begin
            m_vert_reg  <= '0;
            m_tuser_reg <= 1'b1;
            m_tlast_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(8-VW){1'b0}}, m_vert_reg};
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Status to the controller
    assign sts.last_item = last_reg;
    assign sts.pre_bad   = fault_reg || ({1'b0, start_reg} >= n_act)
                           || ({1'b0, end_reg} >= n_act);
    assign sts.bal_ok    = (bal_lhs == bal_rhs);
    assign sts.bal_last  = (u_reg == n_act - CW'(1));
    assign sts.top_empty = top_empty;
    assign sts.sp_one    = (sp_reg == CW'(1));
    assign sts.len_ok    = (len_reg == edge_total_reg + CW'(1));
    assign sts.out_free  = !m_tvalid_reg || m_tready;
    assign sts.idx_zero  = (idx_reg == '0);

    // Checks
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (sp_reg < ND))
        else $error("walk stack overflow");

    a_trail_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.retire |-> (len_reg < ND))
        else $error("trail store overflow");

    a_fail_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("impossible result not a lone zero result");

    a_out_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_load || cmd.fail_load) |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a pending transfer");

    a_edge_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        edge_total_reg <= NE)
        else $error("edge count beyond store depth");

endmodule

[design/directed_euler_trail.sv]
`timescale 1ns / 1ps
// Directed Eulerian trail finder. Each input transfer carries one edge
// (s_tuser high), captured in S_IDLE and stored in S_LOAD; s_tlast starts
// the search on the edges stored so far. The search first scans the degree
// balance over the V active vertices (S_BAL_RD, S_BAL_CMP per vertex), then
// walks the stack (each edge step reads the list head, then the edge store,
// both single-port memories with registered reads), then loads each result
// into the output register, waiting while it is still held. A failed check
// gives a single result with m_tuser high. Stores are cleared after each graph.
module directed_euler_trail #(
    parameter int MAX_VERTICES = det_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = det_pkg::DEF_MAX_EDGES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_we,
    input  logic [det_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [det_pkg::CFG_W-1:0]     cfg_data,
    // edge input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,  // from_vertex[5:0], to_vertex[11:6]
    input  logic                          s_tuser,  // has_edge
    input  logic                          s_tlast,  // last_edge
    // trail output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,  // trail_vertex[5:0]
    output logic                          m_tuser,  // impossible
    output logic                          m_tlast   // last_result
);

    det_pkg::det_cmd_t cmd;
    det_pkg::det_sts_t sts;

    det_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    det_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
